[hdl/ptds_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic task due scheduler package
// Shared sizes, operation codes, command beat type and a helper function.
// ----------------------------------------------------------------------------
package ptds_pkg;

  localparam int NUM_TASKS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W       = $clog2(NUM_TASKS + 1);
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);
  localparam int CMP_W       = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_REGISTER = 2'd1;
  localparam logic [1:0] MODE_ENABLE  = 2'd2;
  localparam logic [1:0] MODE_DISABLE = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_REGISTER,
    OP_ENABLE,
    OP_DISABLE
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } sched_state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic        start_enabled;
    logic [3:0]  task_index;
  } cmd_t;

  function automatic logic [2:0] to_fired_index(input logic [CNT_W-1:0] slot);
    logic [CNT_W+2:0] wide;
    wide = {3'b000, slot};
    return wide[2:0];
  endfunction

endpackage

[hdl/ptds_front.sv]
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input beats, decodes the mode into an operation and buffers the
// commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ptds_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [31:0]      in_now_ms,
  input  logic [31:0]      in_interval_ms,
  input  logic             in_start_enabled,
  input  logic [3:0]       in_task_index,
  output logic             q_valid,
  output ptds_pkg::cmd_t   q_cmd,
  input  logic             q_pop
);

  ptds_pkg::cmd_t cmd_in;
  ptds_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           push, pop;

  always_comb begin
    cmd_in.now_ms        = in_now_ms;
    cmd_in.interval_ms   = in_interval_ms;
    cmd_in.start_enabled = in_start_enabled;
    cmd_in.task_index    = in_task_index;
    unique case (in_mode)
      ptds_pkg::MODE_TICK:     cmd_in.op = ptds_pkg::OP_TICK;
      ptds_pkg::MODE_REGISTER: cmd_in.op = ptds_pkg::OP_REGISTER;
      ptds_pkg::MODE_ENABLE:   cmd_in.op = ptds_pkg::OP_ENABLE;
      default:                 cmd_in.op = ptds_pkg::OP_DISABLE;
    endcase
  end

  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

[hdl/ptds_back.sv]
// ----------------------------------------------------------------------------
// Scheduler back end
// Holds the task table, executes queued commands, walks the table one slot per
// cycle on a tick unless output stalls; drives the registered result channel.
// ----------------------------------------------------------------------------
module ptds_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ptds_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_ok,
  output logic             out_fired,
  output logic [2:0]       out_fired_index,
  output logic [31:0]      out_fire_time,
  output logic             out_last
);

  ptds_pkg::sched_state_t state_r, state_nxt;

  logic [ptds_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ptds_pkg::CNT_W-1:0]  walk_r, walk_nxt;
  logic [ptds_pkg::CNT_W-1:0]  pidx_r, pidx_nxt;
  logic [ptds_pkg::FIRE_W-1:0] nfire_r, nfire_nxt;
  logic [31:0]                 now_r, now_nxt;
  logic                        pend_r, pend_nxt;

  logic [31:0] period_r   [ptds_pkg::NUM_TASKS];
  logic [31:0] last_run_r [ptds_pkg::NUM_TASKS];
  logic        enable_r   [ptds_pkg::NUM_TASKS];

  logic        out_valid_r, out_valid_nxt;
  logic        ok_r, ok_nxt;
  logic        fired_r, fired_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [31:0] time_r, time_nxt;
  logic        last_r, last_nxt;

  logic                       per_we, lr_we, en_we;
  logic [ptds_pkg::IDX_W-1:0] per_waddr, lr_waddr, en_waddr;
  logic [31:0]                per_wdata, lr_wdata;
  logic                       en_wdata;

  logic                       can_emit, emit;
  logic                       e_ok, e_fired, e_last;
  logic [2:0]                 e_fidx;
  logic [31:0]                e_time;
  logic [ptds_pkg::IDX_W-1:0] walk_idx, count_idx;
  logic [31:0]                elapsed;
  logic                       due, walk_done, table_full, idx_ok;
  logic [ptds_pkg::CMP_W-1:0] idx_ext, count_ext;

  assign walk_idx   = walk_r[ptds_pkg::IDX_W-1:0];
  assign count_idx  = count_r[ptds_pkg::IDX_W-1:0];
  assign elapsed    = now_r - last_run_r[walk_idx];
  assign due        = enable_r[walk_idx] && (elapsed >= period_r[walk_idx]);
  assign walk_done  = (walk_r >= count_r) ||
                      (nfire_r == ptds_pkg::FIRE_W'(ptds_pkg::MAX_RESULTS));
  assign table_full = (count_r == ptds_pkg::CNT_W'(ptds_pkg::NUM_TASKS));
  assign idx_ext    = ptds_pkg::CMP_W'(q_cmd.task_index);
  assign count_ext  = ptds_pkg::CMP_W'(count_r);
  assign idx_ok     = (idx_ext < count_ext);
  assign can_emit   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    walk_nxt  = walk_r;
    pidx_nxt  = pidx_r;
    nfire_nxt = nfire_r;
    now_nxt   = now_r;
    pend_nxt  = pend_r;
    q_pop     = 1'b0;
    per_we    = 1'b0;
    lr_we     = 1'b0;
    en_we     = 1'b0;
    per_waddr = count_idx;
    per_wdata = q_cmd.interval_ms;
    lr_waddr  = count_idx;
    lr_wdata  = 32'd0;
    en_waddr  = count_idx;
    en_wdata  = q_cmd.start_enabled;
    emit      = 1'b0;
    e_ok      = 1'b1;
    e_fired   = 1'b0;
    e_fidx    = 3'd0;
    e_time    = 32'd0;
    e_last    = 1'b1;
    unique case (state_r)
      ptds_pkg::ST_IDLE: begin
        if (q_valid && can_emit) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            ptds_pkg::OP_TICK: begin
              now_nxt   = q_cmd.now_ms;
              walk_nxt  = '0;
              nfire_nxt = '0;
              pend_nxt  = 1'b0;
              state_nxt = ptds_pkg::ST_WALK;
            end
            ptds_pkg::OP_REGISTER: begin
              emit = 1'b1;
              if (table_full) begin
                e_ok = 1'b0;
              end else begin
                per_we    = 1'b1;
                lr_we     = 1'b1;
                en_we     = 1'b1;
                e_fidx    = ptds_pkg::to_fired_index(count_r);
                count_nxt = count_r + ptds_pkg::CNT_W'(1);
              end
            end
            default: begin
              emit     = 1'b1;
              e_ok     = idx_ok;
              en_waddr = q_cmd.task_index[ptds_pkg::IDX_W-1:0];
              en_wdata = (q_cmd.op == ptds_pkg::OP_ENABLE);
              en_we    = idx_ok;
            end
          endcase
        end
      end
      ptds_pkg::ST_WALK: begin
        lr_waddr = walk_idx;
        lr_wdata = now_r;
        if (walk_done) begin
          if (can_emit) begin
            emit      = 1'b1;
            e_fired   = pend_r;
            e_fidx    = pend_r ? ptds_pkg::to_fired_index(pidx_r) : 3'd0;
            e_time    = pend_r ? now_r : 32'd0;
            state_nxt = ptds_pkg::ST_IDLE;
          end
        end else if (!due) begin
          walk_nxt = walk_r + ptds_pkg::CNT_W'(1);
        end else if (!pend_r || can_emit) begin
          emit      = pend_r;
          e_fired   = 1'b1;
          e_fidx    = ptds_pkg::to_fired_index(pidx_r);
          e_time    = now_r;
          e_last    = 1'b0;
          pend_nxt  = 1'b1;
          pidx_nxt  = walk_r;
          lr_we     = 1'b1;
          nfire_nxt = nfire_r + ptds_pkg::FIRE_W'(1);
          walk_nxt  = walk_r + ptds_pkg::CNT_W'(1);
        end
      end
      default: state_nxt = ptds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    ok_nxt        = ok_r;
    fired_nxt     = fired_r;
    fidx_nxt      = fidx_r;
    time_nxt      = time_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = e_ok;
      fired_nxt     = e_fired;
      fidx_nxt      = e_fidx;
      time_nxt      = e_time;
      last_nxt      = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      nfire_r     <= '0;
      walk_r      <= '0;
      for (int k = 0; k < ptds_pkg::NUM_TASKS; k++) begin
        enable_r[k] <= 1'b0;
      end
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      nfire_r     <= nfire_nxt;
      walk_r      <= walk_nxt;
      if (en_we) begin
        enable_r[en_waddr] <= en_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    now_r  <= now_nxt;
    ok_r   <= ok_nxt;
    fired_r <= fired_nxt;
    fidx_r <= fidx_nxt;
    time_r <= time_nxt;
    last_r <= last_nxt;
    if (per_we) begin
      period_r[per_waddr] <= per_wdata;
    end
    if (lr_we) begin
      last_run_r[lr_waddr] <= lr_wdata;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_fired       = fired_r;
  assign out_fired_index = fidx_r;
  assign out_fire_time   = time_r;
  assign out_last        = last_r;

endmodule

[hdl/periodic_task_due_scheduler_core.sv]
// With the queue empty and the back end idle, a register, enable or disable beat is
// written into the queue, then executed and its result registered on the output.
// A tick holds the back end while it walks the table one slot per cycle through the
// single compare unit; the walk pauses while the output stalls.
// Synchronous active-low reset clears the queue, the walk state, the task count and
// the enable bits; the period and last-run tables are not cleared.
// ----------------------------------------------------------------------------
// Periodic task due scheduler core
// Top level: command front end, two-entry queue and table executor.
// ----------------------------------------------------------------------------
module periodic_task_due_scheduler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_interval_ms,
  input  logic        in_start_enabled,
  input  logic [3:0]  in_task_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic        out_fired,
  output logic [2:0]  out_fired_index,
  output logic [31:0] out_fire_time,
  output logic        out_last
);

  logic           q_valid;
  logic           q_pop;
  ptds_pkg::cmd_t q_cmd;

  ptds_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_now_ms        (in_now_ms),
    .in_interval_ms   (in_interval_ms),
    .in_start_enabled (in_start_enabled),
    .in_task_index    (in_task_index),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop)
  );

  ptds_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_fired       (out_fired),
    .out_fired_index (out_fired_index),
    .out_fire_time   (out_fire_time),
    .out_last        (out_last)
  );

endmodule

[hdl/ptds_checker.sv]
// ----------------------------------------------------------------------------
// Scheduler port checker
// Checks result beats seen on the top-level ports.
// ----------------------------------------------------------------------------
module ptds_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic        out_fired,
  input logic [2:0]  out_fired_index,
  input logic [31:0] out_fire_time,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fire_time) &&
      $stable(out_fired_index) && $stable(out_last))
    else $error("Result beat changed while stalled.");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_ok)
    else $error("Fired result without ok.");

  a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_last && out_fire_time == 32'd0)
    else $error("Non-fired result must be a single final beat with zero time.");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_fired_index == 3'd0)
    else $error("Rejected operation reports a slot.");

endmodule

bind periodic_task_due_scheduler_core ptds_assertions u_ptds_assertions (.*);
